// ===== src/mctm_pkg.sv =====
// ----------------------------------------------------------------------------
// mctm_pkg: shared types and constants for the motor current/torque model
// Fixed widths, register codes and the multiplier request bundle.
// ----------------------------------------------------------------------------
package mctm_pkg;

  // fraction bits of every Q16.16 quantity
  localparam int FRAC_BITS = 16;
  // duty is Q1.15
  localparam int DUTY_FRAC = 15;

  // serial multiplier operand widths
  localparam int MUL_AW = 57;
  localparam int MUL_BW = 32;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  // divide-by-one-million unit: dividend and quotient widths
  localparam int DIV_NW = 63;
  localparam int DIV_QW = 43;
  localparam int DIV_RW = DIV_NW - DIV_QW;

  localparam logic [DIV_RW-1:0] US_PER_S       = DIV_RW'(1000000);
  localparam logic [31:0]       BURST_LIMIT_US = 32'd1000000;
  localparam logic [47:0]       RECOVER_US     = 48'd3000000;

  // register reset values
  localparam logic [23:0] RST_VMAX   = 24'd3145728;
  localparam logic [23:0] RST_RES    = 24'd11141;
  localparam logic [31:0] RST_INV_L  = 32'd1149754409;
  localparam logic [23:0] RST_KE     = 24'd6567;
  localparam logic [23:0] RST_KT     = 24'd6881;
  localparam logic [23:0] RST_ILIM   = 24'd1461453;
  localparam logic [23:0] RST_TRATED = 24'd589824;
  localparam logic [23:0] RST_TPEAK  = 24'd1179648;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_VMAX   = 3'd0,
    CFG_RES    = 3'd1,
    CFG_INV_L  = 3'd2,
    CFG_KE     = 3'd3,
    CFG_KT     = 3'd4,
    CFG_ILIM   = 3'd5,
    CFG_TRATED = 3'd6,
    CFG_TPEAK  = 3'd7
  } cfg_idx_t;

  // request to the serial multiplier
  typedef struct packed {
    logic              start;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

endpackage

// ===== src/mctm_mul.sv =====
// ----------------------------------------------------------------------------
// mctm_mul: bit-serial shift-add multiplier
// One multiplier bit per cycle, LSB first, 57 x 32 -> 89 bit unsigned.
// ----------------------------------------------------------------------------
module mctm_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  mctm_pkg::mul_req_t                req,
  output logic                              done,
  output logic [mctm_pkg::MUL_PW-1:0]       prod
);
  import mctm_pkg::*;

  localparam int CW = $clog2(MUL_BW + 1);

  logic [MUL_AW-1:0] a_r;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [MUL_AW:0]   sum;

  // add the multiplicand into the high half when the low bit is set
  assign sum = {1'b0, prod[MUL_PW-1:MUL_BW]} + (prod[0] ? {1'b0, a_r} : '0);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(MUL_BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // product shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      prod <= {{MUL_AW{1'b0}}, req.b};
    end else if (busy) begin
      prod <= {sum, prod[MUL_BW-1:1]};
    end
  end

endmodule

// ===== src/mctm_div.sv =====
// ----------------------------------------------------------------------------
// mctm_div: restoring divider by one million
// One quotient bit per cycle over the low quotient bits of the dividend.
// ----------------------------------------------------------------------------
module mctm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mctm_pkg::DIV_NW-1:0] num,
  output logic                        done,
  output logic [mctm_pkg::DIV_QW-1:0] quo
);
  import mctm_pkg::*;

  localparam int CW = $clog2(DIV_QW + 1);

  logic [DIV_RW-1:0] rem;
  logic [DIV_RW:0]   trial;
  logic              fits;
  logic [CW-1:0]     cnt;
  logic              busy;

  // next partial remainder and quotient bit
  assign trial = {rem, quo[DIV_QW-1]};
  assign fits  = trial >= {1'b0, US_PER_S};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[DIV_NW-1:DIV_QW];
      quo <= num[DIV_QW-1:0];
    end else if (busy) begin
      rem <= fits ? DIV_RW'(trial - {1'b0, US_PER_S}) : trial[DIV_RW-1:0];
      quo <= {quo[DIV_QW-2:0], fits};
    end
  end

endmodule

// ===== src/dc_motor_current_torque_model.sv =====
// ----------------------------------------------------------------------------
// dc_motor_current_torque_model: DC motor current and torque, one tick per item
// Forward Euler current step, current clamp, torque with burst limiting.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one tick: duty, shaft_speed,
//   speed_present, tick_us, now_us. Output channel (out_valid/out_stall)
//   returns exactly one result per tick: torque_cmd, winding_current and
//   torque_valid. Configuration writes (cfg_valid/cfg_ready, always ready)
//   must go in only while the block is idle; the block does not enforce it.
//   Sequence: with speed present, a tick takes six passes through the one
//   bit-serial multiplier (voltage, back emf, resistive drop, dt, 1/L,
//   then torque), with the divide by one million (43-bit quotient) between
//   the 1/L and torque passes, and a burst step. With speed absent the tick
//   goes straight to the result step, skipping both serial units.
//   Throughput: one tick at a time; in_stall is high from accept until the
//   result is moved into the output register.
//   The output register holds a result while out_stall is high; the next
//   tick can be accepted and worked on meanwhile, and waits only to load.
//   Reset (rst, synchronous) clears current and burst state and loads the
//   default motor constants; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dc_motor_current_torque_model (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // tick input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] duty,
  input  logic signed [31:0] shaft_speed,
  input  logic               speed_present,
  input  logic [15:0]        tick_us,
  input  logic [47:0]        now_us,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [24:0] torque_cmd,
  output logic signed [24:0] winding_current,
  output logic               torque_valid
);
  import mctm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_VOLT  = 10'b0000000010,
    S_BEMF  = 10'b0000000100,
    S_DROP  = 10'b0000001000,
    S_DTICK = 10'b0000010000,
    S_DINV  = 10'b0000100000,
    S_DIV   = 10'b0001000000,
    S_TORQ  = 10'b0010000000,
    S_BURST = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state;

  // configuration registers
  logic [23:0] vmax, res, ke, kt, ilim, trated, tpeak;
  logic [31:0] inv_l;

  // motor state
  logic signed [24:0] motor_current;
  logic [31:0]        burst_time;
  logic [47:0]        last_high;

  // latched tick
  logic signed [15:0] duty_r;
  logic signed [31:0] speed_r;
  logic               present_r;
  logic [15:0]        tick_r;
  logic [47:0]        now_r;

  // working values
  logic signed [42:0] diff;
  logic signed [24:0] res_torque;
  logic               inv_pass;

  // serial units
  mul_req_t            mul_req;
  logic                mul_done;
  logic [MUL_PW-1:0]   prod;
  logic                div_start;
  logic [DIV_NW-1:0]   div_num;
  logic                div_done;
  logic [DIV_QW-1:0]   step;

  mctm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (prod)
  );

  mctm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quo   (step)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // magnitudes of signed operands
  logic [32:0] speed_mag;
  logic [24:0] cur_mag;
  logic [42:0] diff_mag;
  assign speed_mag = speed_r[31] ? 33'd0 - {speed_r[31], speed_r} : {1'b0, speed_r};
  assign cur_mag   = motor_current[24] ? 25'd0 - motor_current : motor_current;
  assign diff_mag  = diff[42] ? 43'd0 - diff : diff;

  // scaled-back products
  logic [24:0] volts_mag;
  logic [39:0] bemf_mag;
  logic [31:0] drop_mag;
  logic [31:0] tmag;
  assign volts_mag = prod[DUTY_FRAC+24:DUTY_FRAC];
  assign bemf_mag  = prod[FRAC_BITS+39:FRAC_BITS];
  assign drop_mag  = prod[FRAC_BITS+31:FRAC_BITS];
  assign tmag      = prod[FRAC_BITS+31:FRAC_BITS];

  logic signed [42:0] volts_s, bemf_s, drop_s;
  assign volts_s = duty_r[15] ? -$signed({18'd0, volts_mag}) : $signed({18'd0, volts_mag});
  assign bemf_s  = speed_r[31] ? -$signed({3'd0, bemf_mag}) : $signed({3'd0, bemf_mag});
  assign drop_s  = motor_current[24] ? -$signed({11'd0, drop_mag})
                                     : $signed({11'd0, drop_mag});

  // euler increment saturated at 2^62 before the divide
  logic step_sat;
  assign step_sat = (|prod[MUL_PW-1:FRAC_BITS+63])
                  || (prod[FRAC_BITS+62] && (|prod[FRAC_BITS+61:FRAC_BITS]));

  // current update and clamp
  logic signed [44:0] cur_sum, lim_s;
  logic signed [24:0] cur_new;
  assign lim_s   = $signed({21'd0, ilim});
  assign cur_sum = diff[42] ? 45'(motor_current) - $signed({2'd0, step})
                            : 45'(motor_current) + $signed({2'd0, step});
  always_comb begin
    if (cur_sum > lim_s) begin
      cur_new = $signed({1'b0, ilim});
    end else if (cur_sum < -lim_s) begin
      cur_new = -$signed({1'b0, ilim});
    end else begin
      cur_new = cur_sum[24:0];
    end
  end

  // burst timer and torque limiting
  logic        t_high, b_over, recover;
  logic [32:0] b_sum;
  logic [31:0] b_sat, b_dec;
  logic [47:0] elapsed;
  logic [23:0] t_sel;
  logic signed [24:0] t_out;
  assign t_high  = tmag > {8'd0, trated};
  assign b_sum   = {1'b0, burst_time} + {17'd0, tick_r};
  assign b_sat   = b_sum[32] ? '1 : b_sum[31:0];
  assign b_over  = b_sat > BURST_LIMIT_US;
  assign b_dec   = (burst_time > {16'd0, tick_r}) ? burst_time - {16'd0, tick_r} : '0;
  assign elapsed = now_r - last_high;
  assign recover = (now_r > last_high) && (elapsed > RECOVER_US);
  always_comb begin
    if (!t_high) begin
      t_sel = tmag[23:0];
    end else if (b_over) begin
      t_sel = trated;
    end else if (tmag > {8'd0, tpeak}) begin
      t_sel = tpeak;
    end else begin
      t_sel = tmag[23:0];
    end
  end
  assign t_out = motor_current[24] ? -$signed({1'b0, t_sel}) : $signed({1'b0, t_sel});

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vmax   <= RST_VMAX;
      res    <= RST_RES;
      inv_l  <= RST_INV_L;
      ke     <= RST_KE;
      kt     <= RST_KT;
      ilim   <= RST_ILIM;
      trated <= RST_TRATED;
      tpeak  <= RST_TPEAK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VMAX:   vmax   <= cfg_data[23:0];
        CFG_RES:    res    <= cfg_data[23:0];
        CFG_INV_L:  inv_l  <= cfg_data;
        CFG_KE:     ke     <= cfg_data[23:0];
        CFG_KT:     kt     <= cfg_data[23:0];
        CFG_ILIM:   ilim   <= cfg_data[23:0];
        CFG_TRATED: trated <= cfg_data[23:0];
        CFG_TPEAK:  tpeak  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // tick latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      duty_r    <= duty;
      speed_r   <= shaft_speed;
      present_r <= speed_present;
      tick_r    <= tick_us;
      now_r     <= now_us;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      motor_current <= '0;
      burst_time    <= '0;
      last_high     <= '0;
      inv_pass      <= 1'b0;
      mul_req.start <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_start     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            // direction reversal drops the stored current
            if ((duty > 0 && motor_current < 0) || (duty < 0 && motor_current > 0)) begin
              motor_current <= '0;
            end
            res_torque <= '0;
            if (speed_present) begin
              mul_req.start <= 1'b1;
              mul_req.a     <= {{(MUL_AW-16){1'b0}}, duty[15] ? 16'd0 - duty : duty};
              mul_req.b     <= {8'd0, vmax};
              state         <= S_VOLT;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_VOLT: begin
          if (mul_done) begin
            diff          <= volts_s;
            mul_req.start <= 1'b1;
            mul_req.a     <= {24'd0, speed_mag};
            mul_req.b     <= {8'd0, ke};
            state         <= S_BEMF;
          end
        end
        S_BEMF: begin
          if (mul_done) begin
            diff          <= diff - bemf_s;
            mul_req.start <= 1'b1;
            mul_req.a     <= {32'd0, cur_mag};
            mul_req.b     <= {8'd0, res};
            state         <= S_DROP;
          end
        end
        S_DROP: begin
          if (mul_done) begin
            diff          <= diff - drop_s;
            state         <= S_DTICK;
          end
        end
        S_DTICK: begin
          // first pass: launch |diff| * dt
          mul_req.start <= 1'b1;
          mul_req.a     <= {14'd0, diff_mag};
          mul_req.b     <= {16'd0, tick_r};
          inv_pass      <= 1'b0;
          state         <= S_DINV;
        end
        S_DINV: begin
          if (mul_done) begin
            if (!inv_pass) begin
              // second pass: times 1/L
              inv_pass      <= 1'b1;
              mul_req.start <= 1'b1;
              mul_req.a     <= prod[MUL_AW-1:0];
              mul_req.b     <= inv_l;
            end else begin
              div_start <= 1'b1;
              div_num   <= step_sat ? {1'b1, {(DIV_NW-1){1'b0}}}
                                    : prod[FRAC_BITS+DIV_NW-1:FRAC_BITS];
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            motor_current <= cur_new;
            mul_req.start <= 1'b1;
            mul_req.a     <= {32'd0, cur_new[24] ? 25'd0 - cur_new : cur_new};
            mul_req.b     <= {8'd0, kt};
            state         <= S_TORQ;
          end
        end
        S_TORQ: begin
          if (mul_done) begin
            state <= S_BURST;
          end
        end
        S_BURST: begin
          res_torque <= t_out;
          if (t_high) begin
            burst_time <= b_sat;
            last_high  <= now_r;
          end else if (recover) begin
            burst_time <= b_dec;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      torque_cmd      <= res_torque;
      winding_current <= motor_current;
      torque_valid    <= present_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_VOLT || state == S_BEMF || state == S_DROP
                  || state == S_DINV || state == S_TORQ))
    else $error("multiplier finished outside a multiply step");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_absent_fast: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !speed_present |=> state == S_FIN)
    else $error("tick without speed did not go straight to result");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !torque_valid |-> torque_cmd == '0)
    else $error("torque given for a tick without speed");
`endif

endmodule
